// File: hdl/cqp_pkg.sv
package cqp_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [1:0] MODE_ENQ = 2'd0;
   localparam logic [1:0] MODE_DEQ = 2'd1;
   localparam logic [1:0] MODE_ADD = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam logic SEL_HEAD = 1'b0;
   localparam logic SEL_REAR = 1'b1;

   typedef struct packed {
      logic load;
      logic exec;
      logic rd_sel;
      logic cap_head;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic empty_next;
   } stat_type;

endpackage

// File: hdl/cqp_ram.sv
module cqp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/cqp_ctrl.sv
module cqp_ctrl
   import cqp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_RDH  = 3'd2;
   localparam logic [2:0] S_RDT  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rd_sel   = SEL_HEAD;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.empty_next ? S_EMIT : S_RDH;
         end
         S_RDH: begin
            state_in = S_RDT;
         end
         S_RDT: begin
            cmd.cap_head = 1'b1;
            cmd.rd_sel   = SEL_REAR;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: hdl/cqp_datapath.sv
module cqp_datapath
   import cqp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [CNT_W-1:0]         cap_raw,
   input  logic [1:0]               req_mode,
   input  logic signed [DATA_W-1:0] req_operand,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_taken_value,
   output logic signed [DATA_W-1:0] rsp_head_value,
   output logic signed [DATA_W-1:0] rsp_tail_value,
   output logic [CNT_W-1:0]         rsp_fill_count,
   output logic                     rsp_is_empty
);

   logic [1:0]        mode_ff;
   logic [DATA_W-1:0] operand_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in, count_exec;
   logic [1:0]        res_status_ff, res_status_in;
   logic [DATA_W-1:0] taken_ff, taken_in;
   logic [DATA_W-1:0] headval_ff;

   logic                     valid_ff;
   logic [1:0]               out_status_ff;
   logic [DATA_W-1:0]        out_taken_ff, out_head_ff, out_tail_ff;
   logic [CNT_W-1:0]         out_fill_ff;
   logic                     out_empty_ff;

   logic [CNT_W-1:0]  cap;
   logic [IDX_W-1:0]  head_next, tail_next, rear;
   logic              we;
   logic [IDX_W-1:0]  waddr, raddr;
   logic [DATA_W-1:0] wdata, rdata;

   always_comb begin
      cap = cap_raw;
      if (cap_raw == '0) begin
         cap = CNT_W'(1);
      end else if (cap_raw > CNT_W'(DEPTH)) begin
         cap = CNT_W'(DEPTH);
      end
   end

   assign head_next = (({1'b0, head_ff} + CNT_W'(1)) >= cap) ? '0 : head_ff + IDX_W'(1);
   assign tail_next = (({1'b0, tail_ff} + CNT_W'(1)) >= cap) ? '0 : tail_ff + IDX_W'(1);
   assign rear      = (tail_ff == '0) ? IDX_W'(cap - CNT_W'(1)) : tail_ff - IDX_W'(1);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_exec    = count_ff;
      res_status_in = STAT_DONE;
      taken_in      = '0;
      we            = 1'b0;
      waddr         = tail_ff;
      wdata         = operand_ff;
      case (mode_ff)
         MODE_ENQ: begin
            if (count_ff >= cap) begin
               res_status_in = STAT_FULL;
            end else begin
               we         = cmd.exec;
               tail_in    = tail_next;
               count_exec = count_ff + CNT_W'(1);
            end
         end
         MODE_DEQ: begin
            if (count_ff == '0) begin
               res_status_in = STAT_EMPTY;
               taken_in      = '1;
            end else begin
               taken_in   = rdata;
               head_in    = head_next;
               count_exec = count_ff - CNT_W'(1);
            end
         end
         MODE_ADD: begin
            if (count_ff == '0) begin
               res_status_in = STAT_EMPTY;
            end else begin
               we    = cmd.exec;
               waddr = head_ff;
               wdata = rdata + operand_ff;
            end
         end
         default: begin
         end
      endcase
      count_in = cmd.exec ? count_exec : count_ff;
   end

   assign stat.empty_next = (count_exec == '0);
   assign raddr = (cmd.rd_sel == SEL_REAR) ? rear : head_ff;

   cqp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= cmd.emit;
         if (cmd.exec) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         operand_ff <= req_operand;
      end
      if (cmd.exec) begin
         res_status_ff <= res_status_in;
         taken_ff      <= taken_in;
      end
      if (cmd.cap_head) begin
         headval_ff <= rdata;
      end
      if (cmd.emit) begin
         out_status_ff <= res_status_ff;
         out_taken_ff  <= taken_ff;
         out_head_ff   <= (count_ff == '0) ? '0 : headval_ff;
         out_tail_ff   <= (count_ff == '0) ? '0 : rdata;
         out_fill_ff   <= count_ff;
         out_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_taken_value = out_taken_ff;
   assign rsp_head_value  = out_head_ff;
   assign rsp_tail_value  = out_tail_ff;
   assign rsp_fill_count  = out_fill_ff;
   assign rsp_is_empty    = out_empty_ff;

endmodule

// File: hdl/circular_queue_with_peek.sv
// Channel  | Direction | Handshake                          | Payload
// request  | in        | transfer when start & !busy        | req_mode, req_operand
// response | out       | rsp_valid, one cycle, no stall     | rsp_status .. rsp_is_empty
// csr      | in/out    | APB write on psel&penable&pwrite   | capacity at byte address 0
//
// A new request is taken only when the last one is through and busy has dropped. The
// single read port of the entry RAM sets the order of work (operation read, new head
// read, rear read in turn); the head and rear reads are skipped when the queue is empty
// after the operation. rsp_valid rises at the edge that drops busy. Reset clears
// indices and count; capacity resets to 16. The receiver cannot stall.
module circular_queue_with_peek
   import cqp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_mode,
   input  logic signed [DATA_W-1:0] req_operand,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_taken_value,
   output logic signed [DATA_W-1:0] rsp_head_value,
   output logic signed [DATA_W-1:0] rsp_tail_value,
   output logic [CNT_W-1:0]         rsp_fill_count,
   output logic                     rsp_is_empty,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic [CNT_W-1:0] capacity_ff;
   cmd_type          cmd;
   stat_type         stat;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CNT_W'(16);
      end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         capacity_ff <= pwdata[CNT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == 1'b0) ? {{(32 - CNT_W){1'b0}}, capacity_ff} : '0;

   cqp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   cqp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .cap_raw         (capacity_ff),
      .req_mode        (req_mode),
      .req_operand     (req_operand),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_taken_value (rsp_taken_value),
      .rsp_head_value  (rsp_head_value),
      .rsp_tail_value  (rsp_tail_value),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule
